>>> rtl/tsid_pkg.sv
// Shared types and constants for the triangle strip index decoder.
// No dependencies; every other rtl file refers to it by scoped names.
`default_nettype none

package tsid_pkg;

   // face compression type codes
   localparam logic [7:0] FACE_FULL   = 8'd1;
   localparam logic [7:0] FACE_KEEP_A = 8'd2;
   localparam logic [7:0] FACE_KEEP_B = 8'd3;
   localparam logic [7:0] FACE_SWAP   = 8'd4;

   // smart code constants
   localparam int unsigned DELTA_W            = 17;
   localparam logic [7:0]  SMART_TWO_BYTE_MIN = 8'd128;
   localparam logic [16:0] SMART_BIAS_BYTE    = 17'd64;
   localparam logic [16:0] SMART_BIAS_SHORT   = 17'h0C000;

   // codes consumed per face
   localparam logic [1:0] USED_FULL  = 2'd3;
   localparam logic [1:0] USED_STRIP = 2'd1;

   typedef struct packed {
      logic [7:0]  face_type;
      logic [15:0] delta_a_code;
      logic [15:0] delta_b_code;
      logic [15:0] delta_c_code;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] index_a;
      logic signed [31:0] index_b;
      logic signed [31:0] index_c;
      logic [1:0]         codes_used;
   } rsp_payload_type;

   // decoded deltas and their running sums, all relative to prev_c
   typedef struct packed {
      logic [7:0]                face_type;
      logic signed [DELTA_W-1:0] d_a;
      logic signed [DELTA_W:0]   d_ab;
      logic signed [DELTA_W+1:0] d_abc;
   } delta_word_type;

endpackage

`default_nettype wire

>>> rtl/tsid_smart_dec.sv
// Expands one 16-bit smart code into a signed delta.
// Depends on tsid_pkg for the bias constants.
`default_nettype none

module tsid_smart_dec (
   input  wire logic [15:0]                         code,
   output logic signed [tsid_pkg::DELTA_W-1:0]      delta
);

   logic [7:0] first_byte;

   assign first_byte = code[15:8];

   // one-byte form uses the high byte only, two-byte form the whole code
   always_comb begin
      if (first_byte < tsid_pkg::SMART_TWO_BYTE_MIN) begin
         delta = {9'd0, first_byte} - tsid_pkg::SMART_BIAS_BYTE;
      end else begin
         delta = {1'b0, code} - tsid_pkg::SMART_BIAS_SHORT;
      end
   end

endmodule

`default_nettype wire

>>> rtl/tsid_delta_stage.sv
// Input register: decodes the three smart codes and forms running delta sums.
// Depends on tsid_pkg and tsid_smart_dec.
`default_nettype none

module tsid_delta_stage (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire tsid_pkg::req_payload_type req_payload,
   input  wire logic                     hold,
   output logic                          word_valid,
   output tsid_pkg::delta_word_type      word
);

   logic                                 valid_ff;
   tsid_pkg::delta_word_type             word_ff;
   tsid_pkg::delta_word_type             word_in;
   logic signed [tsid_pkg::DELTA_W-1:0]  dec_a;
   logic signed [tsid_pkg::DELTA_W-1:0]  dec_b;
   logic signed [tsid_pkg::DELTA_W-1:0]  dec_c;

   tsid_smart_dec u_dec_a (.code(req_payload.delta_a_code), .delta(dec_a));
   tsid_smart_dec u_dec_b (.code(req_payload.delta_b_code), .delta(dec_b));
   tsid_smart_dec u_dec_c (.code(req_payload.delta_c_code), .delta(dec_c));

   // stall only while a word is held and the next stage cannot take it
   assign req_stall = valid_ff && hold;

   // running sums so the state stage needs a single add per index
   always_comb begin
      word_in.face_type = req_payload.face_type;
      word_in.d_a       = dec_a;
      word_in.d_ab      = {dec_a[tsid_pkg::DELTA_W-1], dec_a}
                        + {dec_b[tsid_pkg::DELTA_W-1], dec_b};
      word_in.d_abc     = {word_in.d_ab[tsid_pkg::DELTA_W], word_in.d_ab}
                        + {{2{dec_c[tsid_pkg::DELTA_W-1]}}, dec_c};
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         word_ff <= word_in;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

`default_nettype wire

>>> rtl/tsid_index_stage.sv
// Previous-triangle state and result register.
// Depends on tsid_pkg; fed by tsid_delta_stage.
`default_nettype none

module tsid_index_stage (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      word_valid,
   input  wire tsid_pkg::delta_word_type  word,
   output logic                           hold,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output tsid_pkg::rsp_payload_type      rsp_payload
);

   logic [31:0]               prev_a_ff, prev_b_ff, prev_c_ff;
   logic [31:0]               prev_a_in, prev_b_in, prev_c_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   tsid_pkg::rsp_payload_type rsp_payload_ff;
   tsid_pkg::rsp_payload_type rsp_payload_in;
   logic                      out_free;
   logic                      advance;
   logic                      face_ok;
   logic [1:0]                used;
   logic [31:0]               sum_a, sum_ab, sum_abc;

   // output register can load when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign hold     = !out_free;
   assign advance  = word_valid && out_free;

   // delta sums added to the last c index, wrapping at 32 bits
   assign sum_a   = prev_c_ff + {{(32-tsid_pkg::DELTA_W){word.d_a[tsid_pkg::DELTA_W-1]}},
                                 word.d_a};
   assign sum_ab  = prev_c_ff + {{(31-tsid_pkg::DELTA_W){word.d_ab[tsid_pkg::DELTA_W]}},
                                 word.d_ab};
   assign sum_abc = prev_c_ff + {{(30-tsid_pkg::DELTA_W){word.d_abc[tsid_pkg::DELTA_W+1]}},
                                 word.d_abc};

   // face type selects the new triangle
   always_comb begin
      prev_a_in = prev_a_ff;
      prev_b_in = prev_b_ff;
      prev_c_in = sum_a;
      face_ok   = 1'b1;
      used      = tsid_pkg::USED_STRIP;
      case (word.face_type)
         tsid_pkg::FACE_FULL: begin
            prev_a_in = sum_a;
            prev_b_in = sum_ab;
            prev_c_in = sum_abc;
            used      = tsid_pkg::USED_FULL;
         end
         tsid_pkg::FACE_KEEP_A: begin
            prev_b_in = prev_c_ff;
         end
         tsid_pkg::FACE_KEEP_B: begin
            prev_a_in = prev_c_ff;
         end
         tsid_pkg::FACE_SWAP: begin
            prev_a_in = prev_b_ff;
            prev_b_in = prev_a_ff;
         end
         default: begin
            prev_a_in = prev_a_ff;
            prev_b_in = prev_b_ff;
            prev_c_in = prev_c_ff;
            face_ok   = 1'b0;
         end
      endcase
   end

   // result word and its valid flag
   always_comb begin
      rsp_payload_in.index_a    = prev_a_in;
      rsp_payload_in.index_b    = prev_b_in;
      rsp_payload_in.index_c    = prev_c_in;
      rsp_payload_in.codes_used = used;
      rsp_valid_in              = out_free ? (advance && face_ok) : rsp_valid_ff;
   end

   // triangle state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_a_ff <= '0;
         prev_b_ff <= '0;
         prev_c_ff <= '0;
      end else if (advance && face_ok) begin
         prev_a_ff <= prev_a_in;
         prev_b_ff <= prev_b_in;
         prev_c_ff <= prev_c_in;
      end
   end

   // output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (advance && face_ok) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

>>> rtl/triangle_strip_index_decoder.sv
// Triangle strip index decoder: takes one face word per cycle while req_stall
// is low and returns the decoded triangle through the input register and then
// the result register. The only loop is the 32-bit add of a pre-summed delta
// onto the last c index. Faces of an unknown type give no result and leave the
// triangle state alone. req_stall rises only while the input register holds a
// face and the result register is full and stalled.
// Depends on tsid_pkg, tsid_delta_stage, tsid_index_stage.
`default_nettype none

module triangle_strip_index_decoder (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire tsid_pkg::req_payload_type req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output tsid_pkg::rsp_payload_type      rsp_payload
);

   logic                     word_valid;
   tsid_pkg::delta_word_type word;
   logic                     hold;

   tsid_delta_stage u_delta (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .hold        (hold),
      .word_valid  (word_valid),
      .word        (word)
   );

   tsid_index_stage u_index (
      .clock       (clock),
      .reset       (reset),
      .word_valid  (word_valid),
      .word        (word),
      .hold        (hold),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // input side stalls only behind a full, stalled result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && word_valid))
      else $error("input stalled without a blocked result");

   // a result carries either one or three codes
   a_codes_used: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.codes_used == tsid_pkg::USED_FULL ||
                     rsp_payload.codes_used == tsid_pkg::USED_STRIP))
      else $error("bad codes_used on result");

   // an unknown face type moving on produces no result
   a_unknown_face: assert property (@(posedge clock) disable iff (reset)
      (word_valid && !hold && word.face_type != tsid_pkg::FACE_FULL &&
       word.face_type != tsid_pkg::FACE_KEEP_A &&
       word.face_type != tsid_pkg::FACE_KEEP_B &&
       word.face_type != tsid_pkg::FACE_SWAP) |=> !rsp_valid)
      else $error("result produced for unknown face type");

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for triangle_strip_index_decoder: faces in, triangles out.
// A scoreboard class predicts each triangle from the faces the block accepts.
// Depends on tsid_pkg and the decoder rtl.

class triangle_scoreboard;
   logic [31:0] last_a;
   logic [31:0] last_b;
   logic [31:0] last_c;
   tsid_pkg::rsp_payload_type expected_q[$];
   int unsigned errors;
   int unsigned faces_taken;
   int unsigned ignored_faces;
   int unsigned triangles_checked;

   function new();
      last_a = '0;
      last_b = '0;
      last_c = '0;
      errors = 0;
      faces_taken = 0;
      ignored_faces = 0;
      triangles_checked = 0;
   endfunction

   // expand one smart code into a 32-bit two's complement delta
   function logic [31:0] smart_delta(input logic [15:0] code);
      if (code[15:8] < tsid_pkg::SMART_TWO_BYTE_MIN)
         return {24'd0, code[15:8]} - 32'(tsid_pkg::SMART_BIAS_BYTE);
      return {16'd0, code} - 32'(tsid_pkg::SMART_BIAS_SHORT);
   endfunction

   // advance the triangle state for an accepted face and queue its result
   function void note_face(input tsid_pkg::req_payload_type face);
      tsid_pkg::rsp_payload_type triangle;
      logic [31:0] step;
      logic [31:0] held;
      logic [1:0]  used;
      faces_taken++;
      step = smart_delta(face.delta_a_code);
      case (face.face_type)
         tsid_pkg::FACE_FULL: begin
            last_a = step + last_c;
            last_b = smart_delta(face.delta_b_code) + last_a;
            last_c = smart_delta(face.delta_c_code) + last_b;
            used = tsid_pkg::USED_FULL;
         end
         tsid_pkg::FACE_KEEP_A: begin
            last_b = last_c;
            last_c = step + last_c;
            used = tsid_pkg::USED_STRIP;
         end
         tsid_pkg::FACE_KEEP_B: begin
            last_a = last_c;
            last_c = step + last_c;
            used = tsid_pkg::USED_STRIP;
         end
         tsid_pkg::FACE_SWAP: begin
            held = last_a;
            last_a = last_b;
            last_b = held;
            last_c = step + last_c;
            used = tsid_pkg::USED_STRIP;
         end
         default: begin
            // unknown type: no triangle, state untouched
            ignored_faces++;
            return;
         end
      endcase
      triangle.index_a = last_a;
      triangle.index_b = last_b;
      triangle.index_c = last_c;
      triangle.codes_used = used;
      expected_q.push_back(triangle);
   endfunction

   // compare a delivered triangle with the oldest prediction
   function void check_triangle(input tsid_pkg::rsp_payload_type got);
      tsid_pkg::rsp_payload_type want;
      if (expected_q.size() == 0) begin
         $error("triangle delivered with none expected: a %0d b %0d c %0d used %0d",
                got.index_a, got.index_b, got.index_c, got.codes_used);
         errors++;
         return;
      end
      want = expected_q.pop_front();
      triangles_checked++;
      if (got.index_a !== want.index_a) begin
         $error("index_a: expected %0d, got %0d", want.index_a, got.index_a);
         errors++;
      end
      if (got.index_b !== want.index_b) begin
         $error("index_b: expected %0d, got %0d", want.index_b, got.index_b);
         errors++;
      end
      if (got.index_c !== want.index_c) begin
         $error("index_c: expected %0d, got %0d", want.index_c, got.index_c);
         errors++;
      end
      if (got.codes_used !== want.codes_used) begin
         $error("codes_used: expected %0d, got %0d", want.codes_used, got.codes_used);
         errors++;
      end
   endfunction

   function int pending();
      return expected_q.size();
   endfunction
endclass

module tb_top;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RANDOM_FACES = 1300;
   localparam int unsigned HOLD_CYCLES = 80;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   tsid_pkg::req_payload_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   tsid_pkg::rsp_payload_type rsp_payload;

   triangle_scoreboard sb = new();
   int unsigned cycle_count = 0;
   bit steady_tail = 1'b0;
   bit rsp_hold_request = 1'b0;

   triangle_strip_index_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_triangle(rsp_payload);
   end

   // offer one face and hold it until the block takes it
   task automatic send_face(input tsid_pkg::req_payload_type face);
      req_valid <= 1'b1;
      req_payload <= face;
      do @(posedge clock); while (req_stall);
      sb.note_face(face);
   endtask

   task automatic send_fields(input logic [7:0] kind, input logic [15:0] code_a,
                              input logic [15:0] code_b, input logic [15:0] code_c);
      tsid_pkg::req_payload_type face;
      face.face_type = kind;
      face.delta_a_code = code_a;
      face.delta_b_code = code_b;
      face.delta_c_code = code_c;
      send_face(face);
   endtask

   task automatic sender_gap(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // stop offering until every predicted triangle has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic logic [15:0] random_code();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return {1'b0, 15'($urandom_range(0, 32767))};
         3: return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic tsid_pkg::req_payload_type random_face();
      tsid_pkg::req_payload_type face;
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4: face.face_type = tsid_pkg::FACE_FULL;
         5, 6, 7, 8:    face.face_type = tsid_pkg::FACE_KEEP_A;
         9, 10, 11, 12: face.face_type = tsid_pkg::FACE_KEEP_B;
         13, 14, 15, 16: face.face_type = tsid_pkg::FACE_SWAP;
         default:       face.face_type = 8'($urandom_range(0, 255));
      endcase
      face.delta_a_code = random_code();
      face.delta_b_code = random_code();
      face.delta_c_code = random_code();
      return face;
   endfunction

   // receiver: random stall bursts, one long hold-off, none in the tail
   initial begin
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold_request = 1'b0;
         end else if (!steady_tail && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // stimulus
   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: code extremes, every face type, ignored types, unused codes
      send_fields(tsid_pkg::FACE_FULL, 16'h0000, 16'h0000, 16'h0000);
      send_fields(tsid_pkg::FACE_FULL, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      sender_gap(3);
      send_fields(tsid_pkg::FACE_FULL, 16'h8000, 16'hBFFF, 16'hC000);
      send_fields(tsid_pkg::FACE_FULL, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_fields(tsid_pkg::FACE_KEEP_A, 16'h4000, 16'hFFFF, 16'hFFFF);
      send_fields(tsid_pkg::FACE_KEEP_B, 16'h7F00, 16'h1234, 16'h5678);
      send_fields(tsid_pkg::FACE_SWAP, 16'h0080, 16'h0000, 16'h0000);
      send_fields(8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_fields(8'd255, 16'h1234, 16'h8000, 16'h7FFF);
      send_fields(8'd5, 16'hC000, 16'hC000, 16'hC000);
      send_fields(tsid_pkg::FACE_KEEP_A, 16'h8000, 16'hFFFF, 16'h0000);
      sender_gap(1);
      send_fields(tsid_pkg::FACE_KEEP_B, 16'hFFFF, 16'h0000, 16'hFFFF);
      send_fields(tsid_pkg::FACE_SWAP, 16'hC001, 16'hAAAA, 16'h5555);
      send_fields(tsid_pkg::FACE_SWAP, 16'h3FFF, 16'h5555, 16'hAAAA);
      send_fields(tsid_pkg::FACE_FULL, 16'hFF00, 16'h00FF, 16'h4040);
      send_fields(8'd128, 16'h0000, 16'h0000, 16'h0000);
      send_fields(tsid_pkg::FACE_KEEP_A, 16'h0000, 16'h0000, 16'h0000);
      send_fields(tsid_pkg::FACE_FULL, 16'h8001, 16'h8001, 16'h8001);
      send_fields(8'hFE, 16'h7FFF, 16'h8000, 16'hFFFF);
      send_fields(tsid_pkg::FACE_KEEP_B, 16'hBFFF, 16'h0000, 16'h0000);
      wait_drained();

      // random faces, mostly decodable, with a long receiver hold-off and a pause
      for (int unsigned n = 0; n < RANDOM_FACES; n++) begin
         if (n == 400)
            rsp_hold_request = 1'b1;
         if (n == 800)
            wait_drained();
         if (n == RANDOM_FACES - 200)
            steady_tail = 1'b1;
         if (!steady_tail && !rsp_hold_request && $urandom_range(0, 4) == 0)
            sender_gap($urandom_range(1, 9));
         send_face(random_face());
      end
      req_valid <= 1'b0;

      // let the pipeline empty, then report
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("faces accepted: %0d (%0d of unknown type), triangles checked: %0d",
               sb.faces_taken, sb.ignored_faces, sb.triangles_checked);
      $display("covered all face types, code extremes, wrap-around sums and stall bursts");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
